// File: rtl/core/rtcsm_pkg.sv
`timescale 1ns / 1ps
package rtcsm_pkg;

  localparam int unsigned DATA_W = 56;
  localparam int unsigned BIT_W  = 7;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_SINGLE_WRITE = 3'd1,
    OP_SINGLE_READ  = 3'd2,
    OP_BURST_WRITE  = 3'd3,
    OP_BURST_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_SINGLE_WRITE = 2'd0,
    KIND_SINGLE_READ  = 2'd1,
    KIND_BURST_WRITE  = 2'd2,
    KIND_BURST_READ   = 2'd3
  } access_kind_e;

  localparam logic [7:0] CMD_WRITE_BASE  = 8'h80;
  localparam logic [7:0] CMD_READ_BASE   = 8'h81;
  localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
  localparam logic [7:0] CMD_BURST_READ  = 8'hBF;

  // bit count of a single access: command byte plus one data byte
  localparam logic [BIT_W-1:0] SINGLE_BITS = 7'd16;
  localparam logic [BIT_W-1:0] CMD_BITS    = 7'd8;

  typedef struct packed {
    logic              chip_enable;
    logic              serial_clock;
    logic              io_out;
    logic              io_drive;
    logic              busy_res;
    logic              done_res;
    logic              rejected;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

// File: rtl/core/rtcsm_engine.sv
`timescale 1ns / 1ps
module rtcsm_engine #(
  parameter int unsigned BURST_BYTES = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [2:0]                   op_i,
  input  logic [4:0]                   reg_addr_i,
  input  logic [rtcsm_pkg::DATA_W-1:0] write_data_i,
  input  logic                         io_in_i,
  output rtcsm_pkg::result_t           result_o
);
  import rtcsm_pkg::*;

  localparam int unsigned BURST_DATA_W = 8 * BURST_BYTES;
  localparam int unsigned SHIFT_W      = 8 + BURST_DATA_W;
  localparam logic [BIT_W-1:0] BURST_BITS = BIT_W'(SHIFT_W);

  logic               active_q, active_d;
  logic               half_q, half_d;
  logic               clk_lvl_q, clk_lvl_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  access_kind_e       kind_q, kind_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [DATA_W-1:0]  gather_q, gather_d;

  logic               is_start;
  logic               is_read_kind;
  logic               done;
  logic               rejected;
  logic [BIT_W-1:0]   bit_inc;
  logic [BIT_W-1:0]   total_bits;
  logic [BIT_W-1:0]   gather_idx;
  logic [7:0]         cmd;
  logic [SHIFT_W-1:0] load_data;

  // pin view: the state that the pins show for this item
  logic               v_active, v_half, v_clk;
  logic [BIT_W-1:0]   v_bit, sel_bit;
  logic               v_read_bit;
  logic [SHIFT_W-1:0] shifted;
  logic               pin_io, pin_drive;

  always_comb begin
    is_start = 1'b0;
    case (op_i) inside
      OP_SINGLE_WRITE, OP_SINGLE_READ, OP_BURST_WRITE, OP_BURST_READ: is_start = 1'b1;
      default: is_start = 1'b0;
    endcase
  end

  always_comb begin
    cmd       = CMD_BURST_READ;
    load_data = '0;
    case (op_i)
      OP_SINGLE_WRITE: begin
        cmd       = 8'({reg_addr_i, 1'b0}) | CMD_WRITE_BASE;
        load_data = SHIFT_W'(write_data_i[7:0]);
      end
      OP_SINGLE_READ: begin
        cmd = 8'({reg_addr_i, 1'b0}) | CMD_READ_BASE;
      end
      OP_BURST_WRITE: begin
        cmd       = CMD_BURST_WRITE;
        load_data = SHIFT_W'(write_data_i[BURST_DATA_W-1:0]);
      end
      default: begin
        cmd = CMD_BURST_READ;
      end
    endcase
  end

  assign is_read_kind = (kind_q == KIND_SINGLE_READ) || (kind_q == KIND_BURST_READ);
  assign total_bits   = (kind_q == KIND_SINGLE_WRITE || kind_q == KIND_SINGLE_READ) ?
                        SINGLE_BITS : BURST_BITS;
  assign bit_inc      = bit_q + 7'd1;
  assign gather_idx   = bit_q - CMD_BITS;

  always_comb begin
    active_d  = active_q;
    half_d    = half_q;
    clk_lvl_d = clk_lvl_q;
    bit_d     = bit_q;
    kind_d    = kind_q;
    shift_d   = shift_q;
    gather_d  = gather_q;
    done      = 1'b0;
    rejected  = 1'b0;
    v_active  = active_q;
    v_half    = half_q;
    v_clk     = clk_lvl_q;
    v_bit     = bit_q;
    if (is_start) begin
      if (active_q) begin
        rejected = 1'b1;
      end else begin
        kind_d    = access_kind_e'(2'(op_i - 3'd1));
        shift_d   = (load_data << 8) | SHIFT_W'(cmd);
        gather_d  = '0;
        bit_d     = '0;
        half_d    = 1'b0;
        clk_lvl_d = 1'b0;
        active_d  = 1'b1;
        v_active  = 1'b1;
        v_half    = 1'b0;
        v_clk     = 1'b0;
        v_bit     = '0;
      end
    end else if (active_q && !half_q) begin
      // first half: clock low, sample on read data bits
      if (is_read_kind && bit_q >= CMD_BITS) begin
        gather_d = gather_q | (DATA_W'(io_in_i) << gather_idx);
      end
      clk_lvl_d = 1'b0;
      half_d    = 1'b1;
      v_clk     = 1'b0;
      v_half    = 1'b1;
    end else if (active_q) begin
      // second half: clock high, then advance to the next bit
      v_clk  = 1'b1;
      half_d = 1'b0;
      bit_d  = bit_inc;
      clk_lvl_d = 1'b1;
      if (bit_inc >= total_bits) begin
        done      = 1'b1;
        active_d  = 1'b0;
        clk_lvl_d = 1'b0;
        bit_d     = '0;
      end
    end
  end

  assign sel_bit    = v_half ? v_bit : v_bit - 7'd1;
  assign v_read_bit = ((kind_d == KIND_SINGLE_READ) || (kind_d == KIND_BURST_READ)) &&
                      (sel_bit >= CMD_BITS);
  assign shifted    = shift_d >> sel_bit;

  always_comb begin
    if (!v_active) begin
      pin_io    = 1'b1;
      pin_drive = 1'b0;
    end else if (!v_half && v_bit == '0) begin
      pin_io    = 1'b1;
      pin_drive = 1'b1;
    end else if (v_read_bit) begin
      pin_io    = 1'b1;
      pin_drive = 1'b0;
    end else begin
      pin_io    = shifted[0];
      pin_drive = 1'b1;
    end
  end

  always_comb begin
    result_o.chip_enable  = v_active;
    result_o.serial_clock = v_clk;
    result_o.io_out       = pin_io;
    result_o.io_drive     = pin_drive;
    result_o.busy_res     = v_active;
    result_o.done_res     = done;
    result_o.rejected     = rejected;
    result_o.read_data    = gather_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      half_q    <= 1'b0;
      clk_lvl_q <= 1'b0;
      bit_q     <= '0;
      kind_q    <= KIND_SINGLE_WRITE;
      shift_q   <= '0;
      gather_q  <= '0;
    end else if (accept_i) begin
      active_q  <= active_d;
      half_q    <= half_d;
      clk_lvl_q <= clk_lvl_d;
      bit_q     <= bit_d;
      kind_q    <= kind_d;
      shift_q   <= shift_d;
      gather_q  <= gather_d;
    end
  end

endmodule

// File: rtl/core/rtc_three_wire_serial_master_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// input    | in_valid_i / in_ready_o | op_i, reg_addr_i, write_data_i, io_in_i
// output   | out_valid_o/out_ready_i | chip_enable_o, serial_clock_o, io_out_o,
//          |                         | io_drive_o, busy_res_o, done_res_o,
//          |                         | rejected_o, read_data_o
//
// One item per clock while in_ready_o is high: the pin sequencer updates in the cycle
// an item is taken and its result is registered. A two-entry output stage (result
// register plus skid register) lets an item be taken while a result waits; input
// stalls only when both entries are full. Reset idles the link, clears the sequencer
// state and read data and empties both entries; their contents are not reset.
module rtc_three_wire_serial_master_top #(
  parameter int unsigned BURST_BYTES = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   op_i,
  input  logic [4:0]                   reg_addr_i,
  input  logic [rtcsm_pkg::DATA_W-1:0] write_data_i,
  input  logic                         io_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         chip_enable_o,
  output logic                         serial_clock_o,
  output logic                         io_out_o,
  output logic                         io_drive_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic                         rejected_o,
  output logic [rtcsm_pkg::DATA_W-1:0] read_data_o
);
  import rtcsm_pkg::*;

  logic    accept;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  rtcsm_engine #(
    .BURST_BYTES(BURST_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .reg_addr_i  (reg_addr_i),
    .write_data_i(write_data_i),
    .io_in_i     (io_in_i),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      // output slot frees: refill from skid first, else from a new item
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = out_q.chip_enable;
  assign serial_clock_o = out_q.serial_clock;
  assign io_out_o       = out_q.io_out;
  assign io_drive_o     = out_q.io_drive;
  assign busy_res_o     = out_q.busy_res;
  assign done_res_o     = out_q.done_res;
  assign rejected_o     = out_q.rejected;
  assign read_data_o    = out_q.read_data;

endmodule
